// File: design/sseg_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment driver package
// Command codes, segment glyph table, character map and setup frames.
// ----------------------------------------------------------------------------
package sseg_pkg;

    typedef enum logic [2:0] {
        REQ_INIT = 3'd0,
        REQ_CHAR = 3'd1,
        REQ_DEC  = 3'd2,
        REQ_HEX  = 3'd3,
        REQ_DP   = 3'd4
    } req_t;

    localparam int unsigned SETUP_COUNT = 6;
    localparam logic [7:0]  SEG_POINT   = 8'h80;
    localparam logic [5:0]  SPACE_INDEX = 6'd36;
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;

    localparam logic [3:0] ADDR_NOOP  = 4'h0;
    localparam logic [3:0] ADDR_DECODE = 4'h9;
    localparam logic [3:0] ADDR_INTENS = 4'hA;
    localparam logic [3:0] ADDR_SCAN  = 4'hB;
    localparam logic [3:0] ADDR_WAKE  = 4'hC;
    localparam logic [3:0] ADDR_TEST  = 4'hF;

    function automatic logic [7:0] glyph(input logic [5:0] idx);
        logic [7:0] seg;
        case (idx)
            6'd0:  seg = 8'h7E;
            6'd1:  seg = 8'h30;
            6'd2:  seg = 8'h6D;
            6'd3:  seg = 8'h79;
            6'd4:  seg = 8'h33;
            6'd5:  seg = 8'h5B;
            6'd6:  seg = 8'h5F;
            6'd7:  seg = 8'h70;
            6'd8:  seg = 8'h7F;
            6'd9:  seg = 8'h73;
            6'd10: seg = 8'h77;
            6'd11: seg = 8'h1F;
            6'd12: seg = 8'h4E;
            6'd13: seg = 8'h3D;
            6'd14: seg = 8'h4F;
            6'd15: seg = 8'h47;
            6'd16: seg = 8'h5E;
            6'd17: seg = 8'h17;
            6'd18: seg = 8'h06;
            6'd19: seg = 8'h3C;
            6'd20: seg = 8'hB7;
            6'd21: seg = 8'h0E;
            6'd22: seg = 8'h95;
            6'd23: seg = 8'h15;
            6'd24: seg = 8'h1D;
            6'd25: seg = 8'h67;
            6'd26: seg = 8'hF3;
            6'd27: seg = 8'h05;
            6'd28: seg = 8'h5B;
            6'd29: seg = 8'h0F;
            6'd30: seg = 8'h3E;
            6'd31: seg = 8'h1C;
            6'd32: seg = 8'hBE;
            6'd33: seg = 8'h37;
            6'd34: seg = 8'h3B;
            6'd35: seg = 8'h6D;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    function automatic logic [7:0] char_to_seg(input logic [7:0] c);
        logic [7:0] seg;
        logic [7:0] low;
        low = c | 8'h20;
        case (c)
            8'h2E:   seg = 8'h80;
            8'h21:   seg = 8'hA0;
            8'h3F:   seg = 8'h65;
            8'h3D:   seg = 8'h09;
            8'h2D:   seg = 8'h01;
            8'h27:   seg = 8'h02;
            8'h22:   seg = 8'h22;
            default: seg = SEG_POINT;
        endcase
        if (c inside {[8'h30:8'h39]})
            seg = glyph(6'(c - 8'h30));
        else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]})
            seg = glyph(6'(low - 8'h61 + 8'd10));
        else if (c == 8'h20)
            seg = glyph(SPACE_INDEX);
        return seg;
    endfunction

    function automatic logic [15:0] setup_frame(input logic [2:0] idx,
                                                input logic [7:0] scan,
                                                input logic [3:0] bright);
        logic [15:0] f;
        case (idx)
            3'd0:    f = {4'h0, ADDR_NOOP, 8'h00};
            3'd1:    f = {4'h0, ADDR_TEST, 8'h00};
            3'd2:    f = {4'h0, ADDR_DECODE, 8'h00};
            3'd3:    f = {4'h0, ADDR_SCAN, scan};
            3'd4:    f = {4'h0, ADDR_INTENS, 4'h0, bright};
            3'd5:    f = {4'h0, ADDR_WAKE, 8'h01};
            default: f = {4'h0, ADDR_NOOP, 8'h00};
        endcase
        return f;
    endfunction

endpackage

// File: design/sseg_digit_unit.sv
// ----------------------------------------------------------------------------
// Seven-segment digit unit
// Produces one digit glyph per step: hex nibble, or decimal digit through a
// registered reciprocal multiply by one tenth.
// ----------------------------------------------------------------------------
module sseg_digit_unit (
    input  logic        clk,
    input  logic [31:0] value,
    input  logic        is_hex,
    output logic [7:0]  seg,
    output logic [31:0] value_next
);
    import sseg_pkg::*;

    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [28:0] quot;
    logic [31:0] ten_quot;
    logic [31:0] rem_full;

    assign prod_next = value * RECIP_10;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign quot     = prod_reg[63:35];
    assign ten_quot = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem_full = value - ten_quot;

    always_comb
    begin
        if (is_hex)
        begin
            seg        = glyph({2'b00, value[3:0]});
            value_next = {4'h0, value[31:4]};
        end
        else
        begin
            seg        = (value == 32'd0) ? 8'h00 : glyph({2'b00, rem_full[3:0]});
            value_next = {3'b000, quot};
        end
    end

endmodule

// File: design/seven_segment_display_driver_core.sv
// ----------------------------------------------------------------------------
// Seven-segment display driver core
// Keeps the digit buffer, runs the commands and sends the driver frames.
//
// Channel   Ports                                   Transfer
// command   start, busy, req_type, char_code,        start && !busy
//           number, dp_mask
// frames    frame_valid, frame, last                 frame_valid (one cycle)
// config    brightness_we, brightness                brightness_we
//
// Insert and point mask go straight to the digit frames. Hex fills each
// digit in STORE; decimal fills each in MUL then STORE, for the multiplier.
// Init: six setup frames then the digit frames.
// Frames leave one per cycle from an output register; busy stays high
// until the last frame is issued. Reset blanks the buffer, brightness is 15.
// ----------------------------------------------------------------------------
module seven_segment_display_driver_core #(
    parameter int DIGITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [7:0]  char_code,
    input  logic [31:0] number,
    input  logic [7:0]  dp_mask,
    input  logic        brightness_we,
    input  logic [3:0]  brightness,
    output logic        frame_valid,
    output logic [15:0] frame,
    output logic        last
);
    import sseg_pkg::*;

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_STORE = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] num_reg, num_next;
    logic        is_hex_reg, is_hex_next;
    logic [3:0]  bright_reg;
    logic [7:0]  seg_reg [DIGITS];
    logic [7:0]  seg_next [DIGITS];
    logic        valid_reg, valid_next;
    logic [15:0] frame_reg, frame_next;
    logic        last_reg, last_next;
    logic [7:0]  unit_seg;
    logic [31:0] unit_num;
    logic [IDX_W-1:0] idx;
    logic        cnt_at_end;

    assign idx        = cnt_reg[IDX_W-1:0];
    assign cnt_at_end = (cnt_reg == 3'(DIGITS - 1));

    sseg_digit_unit u_digit (
        .clk        (clk),
        .value      (num_reg),
        .is_hex     (is_hex_reg),
        .seg        (unit_seg),
        .value_next (unit_num)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        num_next    = num_reg;
        is_hex_next = is_hex_reg;
        seg_next    = seg_reg;
        valid_next  = 1'b0;
        frame_next  = frame_reg;
        last_next   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 3'd0;
                if (start)
                begin
                    case (req_type)
                        REQ_INIT:
                        begin
                            for (int i = 0; i < DIGITS; i++)
                                seg_next[i] = 8'h00;
                            state_next = ST_SETUP;
                        end
                        REQ_CHAR:
                        begin
                            for (int i = DIGITS - 1; i > 0; i--)
                                seg_next[i] = seg_reg[i-1];
                            seg_next[0] = char_to_seg(char_code);
                            state_next  = ST_EMIT;
                        end
                        REQ_DEC:
                        begin
                            num_next    = number;
                            is_hex_next = 1'b0;
                            state_next  = ST_MUL;
                        end
                        REQ_HEX:
                        begin
                            num_next    = number;
                            is_hex_next = 1'b1;
                            state_next  = ST_STORE;
                        end
                        REQ_DP:
                        begin
                            for (int i = 0; i < DIGITS; i++)
                                seg_next[i] = {dp_mask[i], seg_reg[i][6:0]};
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                valid_next = 1'b1;
                frame_next = setup_frame(cnt_reg, 8'(DIGITS - 1), bright_reg);
                if (cnt_reg == 3'(SETUP_COUNT - 1))
                begin
                    cnt_next   = 3'd0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_MUL:
            begin
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                seg_next[idx] = unit_seg;
                num_next      = unit_num;
                if (cnt_at_end)
                begin
                    cnt_next   = 3'd0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = is_hex_reg ? ST_STORE : ST_MUL;
                end
            end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                frame_next = {4'h0, {1'b0, cnt_reg} + 4'd1, seg_reg[idx]};
                last_next  = cnt_at_end;
                if (cnt_at_end)
                begin
                    cnt_next   = 3'd0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 3'd0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
            bright_reg <= 4'hF;
            for (int i = 0; i < DIGITS; i++)
                seg_reg[i] <= 8'h00;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
            if (brightness_we)
                bright_reg <= brightness;
            seg_reg <= seg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        is_hex_reg <= is_hex_next;
        frame_reg  <= frame_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign frame_valid = valid_reg;
    assign frame       = frame_reg;
    assign last        = last_reg;

    a_last_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |-> valid_reg)
        else $error("last without frame strobe");

    a_last_is_top_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |-> (frame_reg[11:8] == 4'(DIGITS)))
        else $error("final frame is not the top digit");

    a_frame_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (frame_reg[15:12] == 4'h0))
        else $error("frame upper bits set");

    a_init_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_INIT) |=> (state_reg == ST_SETUP))
        else $error("init did not enter setup");

    a_store_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE && !cnt_at_end) |=> (cnt_reg == $past(cnt_reg) + 3'd1))
        else $error("digit counter did not advance");

endmodule

// File: dv/seven_segment_display_driver_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment display driver core testbench
// Sends directed and random commands (init, character insert, decimal, hex,
// point mask and unused codes) through the start/busy handshake. It keeps
// its own copy of the digit buffer and brightness, and works out the frames
// each command must produce. Every frame strobe is checked against the oldest
// expected frame, word and last flag. Brightness changes only between phases.
// ----------------------------------------------------------------------------
module seven_segment_display_driver_core_tb;

    import sseg_pkg::*;

    localparam int DIGITS = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;

    localparam logic [2:0] REQ_SPARE_5 = 3'd5;
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam logic [0:36][7:0] GLYPHS = {
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h73,
        8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E, 8'h17, 8'h06, 8'h3C,
        8'hB7, 8'h0E, 8'h95, 8'h15, 8'h1D, 8'h67, 8'hF3, 8'h05, 8'h5B, 8'h0F,
        8'h3E, 8'h1C, 8'hBE, 8'h37, 8'h3B, 8'h6D,
        8'h00
    };
    localparam int BLANK_GLYPH = 36;

    typedef struct packed {
        logic [15:0] word;
        logic        fin;
    } frame_exp_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [7:0]  char_code;
    logic [31:0] number;
    logic [7:0]  dp_mask;
    logic        brightness_we;
    logic [3:0]  brightness;
    logic        frame_valid;
    logic [15:0] frame;
    logic        last;

    frame_exp_t  frames_due[$];
    frame_exp_t  head;
    logic [7:0]  disp_buf [0:DIGITS-1];
    logic [3:0]  intensity;
    bit          steady_run;
    int          bad_frames;
    int          frames_checked;
    int          cmds_sent [0:7];

    seven_segment_display_driver_core #(
        .DIGITS(DIGITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .char_code    (char_code),
        .number       (number),
        .dp_mask      (dp_mask),
        .brightness_we(brightness_we),
        .brightness   (brightness),
        .frame_valid  (frame_valid),
        .frame        (frame),
        .last         (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] char_segments(input logic [7:0] c);
        logic [7:0] seg;
        case (c)
            ".":     seg = 8'h80;
            "!":     seg = 8'hA0;
            "?":     seg = 8'h65;
            "=":     seg = 8'h09;
            "-":     seg = 8'h01;
            "'":     seg = 8'h02;
            "\"":    seg = 8'h22;
            default:
            begin
                if (c >= "0" && c <= "9")
                    seg = GLYPHS[c - "0"];
                else if (c >= "a" && c <= "z")
                    seg = GLYPHS[c - "a" + 10];
                else if (c >= "A" && c <= "Z")
                    seg = GLYPHS[c - "A" + 10];
                else if (c == " ")
                    seg = GLYPHS[BLANK_GLYPH];
                else
                    seg = SEG_POINT;
            end
        endcase
        return seg;
    endfunction

    task automatic push_frame(input logic [15:0] word, input logic fin);
        frame_exp_t entry;
        entry.word = word;
        entry.fin  = fin;
        frames_due.push_back(entry);
    endtask

    task automatic compute_frames(input logic [2:0] op, input logic [7:0] ch,
                                  input logic [31:0] val, input logic [7:0] mask);
        logic [31:0] rest;
        bit          emit;
        int          i;
        rest = val;
        emit = 1'b1;
        case (op)
            REQ_INIT:
            begin
                for (i = 0; i < DIGITS; i++)
                    disp_buf[i] = 8'h00;
                push_frame({4'h0, ADDR_NOOP, 8'h00}, 1'b0);
                push_frame({4'h0, ADDR_TEST, 8'h00}, 1'b0);
                push_frame({4'h0, ADDR_DECODE, 8'h00}, 1'b0);
                push_frame({4'h0, ADDR_SCAN, 8'(DIGITS - 1)}, 1'b0);
                push_frame({4'h0, ADDR_INTENS, 4'h0, intensity}, 1'b0);
                push_frame({4'h0, ADDR_WAKE, 8'h01}, 1'b0);
            end
            REQ_CHAR:
            begin
                for (i = DIGITS - 1; i > 0; i--)
                    disp_buf[i] = disp_buf[i - 1];
                disp_buf[0] = char_segments(ch);
            end
            REQ_DEC:
            begin
                for (i = 0; i < DIGITS; i++)
                begin
                    disp_buf[i] = (rest == 0) ? 8'h00 : GLYPHS[rest % 10];
                    rest = rest / 10;
                end
            end
            REQ_HEX:
            begin
                for (i = 0; i < DIGITS; i++)
                begin
                    disp_buf[i] = GLYPHS[rest[3:0]];
                    rest = rest >> 4;
                end
            end
            REQ_DP:
            begin
                for (i = 0; i < DIGITS; i++)
                    disp_buf[i] = {mask[i], disp_buf[i][6:0]};
            end
            default:
                emit = 1'b0;
        endcase
        if (emit)
            for (i = 0; i < DIGITS; i++)
                push_frame({4'h0, 4'(i + 1), disp_buf[i]}, i == DIGITS - 1);
    endtask

    task automatic report_mismatch(input string what, input frame_exp_t exp_f);
        bad_frames++;
        if (bad_frames <= REPORT_LIMIT)
            $display("%0t: %s: expected frame %h last %b, got frame %h last %b",
                     $realtime, what, exp_f.word, exp_f.fin, frame, last);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && frame_valid)
        begin
            if (frames_due.size() == 0)
            begin
                head = '0;
                report_mismatch("unexpected frame", head);
            end
            else
            begin
                head = frames_due.pop_front();
                frames_checked++;
                if (frame !== head.word || last !== head.fin)
                    report_mismatch("frame mismatch", head);
            end
        end
    end

    // Leaves start high on return; a drain drops it, and so may the next call outside a steady run.
    task automatic send_command(input logic [2:0] op, input logic [7:0] ch,
                                input logic [31:0] val, input logic [7:0] mask);
        if (!steady_run && $urandom_range(0, 99) < 29)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= op;
        char_code <= ch;
        number    <= val;
        dp_mask   <= mask;
        do
            @(posedge clk);
        while (busy);
        compute_frames(op, ch, val, mask);
        cmds_sent[op]++;
    endtask

    task automatic send_init();
        send_command(REQ_INIT, 8'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_command(REQ_CHAR, ch, $urandom, 8'($urandom));
    endtask

    task automatic send_number(input logic [2:0] op, input logic [31:0] val);
        send_command(op, 8'($urandom), val, 8'($urandom));
    endtask

    task automatic send_mask(input logic [7:0] mask);
        send_command(REQ_DP, 8'($urandom), $urandom, mask);
    endtask

    task automatic drain_frames();
        start <= 1'b0;
        while (frames_due.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_brightness(input logic [3:0] level);
        brightness_we <= 1'b1;
        brightness    <= level;
        @(posedge clk);
        brightness_we <= 1'b0;
        intensity = level;
    endtask

    task automatic test_setup_frames();
        set_brightness(4'h0);
        send_init();
        drain_frames();
        set_brightness(4'hF);
        send_init();
    endtask

    task automatic test_char_table();
        string probe;
        int    i;
        probe = ".!?=-'\"9A z";
        for (i = 0; i < probe.len(); i++)
            send_char(probe[i]);
        send_char(8'hFF);
    endtask

    task automatic test_numbers();
        send_number(REQ_DEC, 32'd0);
        send_number(REQ_DEC, 32'hFFFF_FFFF);
        send_number(REQ_DEC, 32'd100);
        send_number(REQ_HEX, 32'h0000_0000);
        send_number(REQ_HEX, 32'hFFFF_FFFF);
    endtask

    task automatic test_point_mask();
        send_mask(8'hFF);
        send_mask(8'h5A);
        send_mask(8'h00);
    endtask

    task automatic test_spare_codes();
        send_command(REQ_SPARE_5, 8'($urandom), $urandom, 8'($urandom));
        send_command(REQ_SPARE_6, 8'($urandom), $urandom, 8'($urandom));
        send_command(REQ_SPARE_7, 8'($urandom), $urandom, 8'($urandom));
        send_mask(8'h81);
    endtask

    task automatic random_command();
        int          pick;
        logic [7:0]  ch;
        logic [31:0] val;
        pick = $urandom_range(0, 99);
        ch   = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h20, 8'h7E))
                                           : 8'($urandom);
        case ($urandom_range(0, 7))
            0:       val = 32'd0;
            1, 2:    val = $urandom_range(0, 999);
            3, 4:    val = $urandom_range(0, 99999999);
            default: val = $urandom;
        endcase
        if (pick < 8)
            send_init();
        else if (pick < 48)
            send_char(ch);
        else if (pick < 65)
            send_number(REQ_DEC, val);
        else if (pick < 80)
            send_number(REQ_HEX, val);
        else if (pick < 95)
            send_mask(8'($urandom));
        else
            send_command(3'(REQ_SPARE_5 + $urandom_range(0, 2)), ch, val,
                         8'($urandom));
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 4; phase++)
        begin
            drain_frames();
            set_brightness(4'($urandom));
            steady_run = (phase == 2);
            send_init();
            repeat (22) random_command();
        end
        steady_run = 1'b0;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = REQ_INIT;
        char_code      = 8'h00;
        number         = 32'h0;
        dp_mask        = 8'h00;
        brightness_we  = 1'b0;
        brightness     = 4'hF;
        intensity      = 4'hF;
        steady_run     = 1'b0;
        bad_frames     = 0;
        frames_checked = 0;
        for (int i = 0; i < DIGITS; i++)
            disp_buf[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            cmds_sent[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_setup_frames();
        test_char_table();
        test_numbers();
        test_point_mask();
        test_spare_codes();
        test_random_traffic();
        drain_frames();

        $display("Commands: init %0d, char %0d, decimal %0d, hex %0d, mask %0d, unused %0d",
                 cmds_sent[REQ_INIT], cmds_sent[REQ_CHAR], cmds_sent[REQ_DEC],
                 cmds_sent[REQ_HEX], cmds_sent[REQ_DP],
                 cmds_sent[REQ_SPARE_5] + cmds_sent[REQ_SPARE_6] + cmds_sent[REQ_SPARE_7]);
        $display("Frames checked %0d, mismatches %0d, frames still owed %0d",
                 frames_checked, bad_frames, frames_due.size());
        if (bad_frames == 0 && frames_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Timeout with %0d frames still owed", frames_due.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
